/* rtl/mi_pkg.sv */
// ----------------------------------------------------------------------------
// mi_pkg: shared types and codes for the modular inverse block
// Holds the sequencer state encoding and the status codes of a result.
// ----------------------------------------------------------------------------
package mi_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ALIGN = 5'b00010,
    ST_SUB   = 5'b00100,
    ST_STEP  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_t;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

endpackage

/* rtl/modular_inverse_top.sv */
// Datapath: one shift-subtract divider serves the reduction of the value and every Euclid step;
//   each quotient passes through scaling (ST_ALIGN), one quotient bit per cycle (ST_SUB) and
//   the step (ST_STEP); after the last step, or at once for modulus 0, ST_FINAL loads the
//   result and raises out_valid once the output register is free, later while out_stall holds.
// Throughput: one item at a time; in_stall is high from the transfer until the result is loaded.
// Reset: rst_n is synchronous and active low; it clears the sequencer and output valid and
//   sets the modulus register to 1.
// ----------------------------------------------------------------------------
// modular_inverse_top: modular inverse by the extended Euclidean algorithm
// Iterative divider under a small sequencer; sign-magnitude Bezout tracking.
// ----------------------------------------------------------------------------
module modular_inverse_top #(
  parameter int DATA_WIDTH = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [DATA_WIDTH-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_inverse,
  output logic                  out_status
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  // Control state
  mi_pkg::state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [W-1:0]   modulus_r;

  // Divider datapath: rem / d, with acc += td for every subtracted d
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   d_r, d_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   td_r, td_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           reduce_r, reduce_nxt;

  // Euclid registers: r0, r1 and coefficient magnitudes; pos_r is the sign of t0
  logic [W-1:0]   r0_r, r0_nxt;
  logic [W-1:0]   r1_r, r1_nxt;
  logic [W-1:0]   t0_r, t0_nxt;
  logic [W-1:0]   t1_r, t1_nxt;
  logic           pos_r, pos_nxt;

  // Output payload
  logic [W-1:0]   out_inverse_r, out_inverse_nxt;
  logic           out_status_r, out_status_nxt;

  // Step and final-stage helpers
  logic [W-1:0]   step_r0, step_t0, step_t1;
  logic           step_pos;
  logic [W:0]     d_dbl;
  logic           sub_ok;
  logic           fail;
  logic [W-1:0]   mag;
  logic           in_xfer, out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign d_dbl    = {d_r, 1'b0};
  assign sub_ok   = (d_r <= rem_r);

  // Next Euclid pair: after the reduction the pair is (m, a mod m); otherwise shift down
  always_comb begin
    if (reduce_r) begin
      step_r0  = modulus_r;
      step_t0  = '0;
      step_t1  = ONE;
      step_pos = 1'b0;
    end else begin
      step_r0  = r1_r;
      step_t0  = t1_r;
      step_t1  = acc_r;
      step_pos = !pos_r;
    end
  end

  // Final mapping of the signed coefficient into 0..m-1
  assign fail = (r0_r != ONE);
  assign mag  = (t0_r >= modulus_r) ? (t0_r - modulus_r) : t0_r;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    rem_nxt         = rem_r;
    d_nxt           = d_r;
    acc_nxt         = acc_r;
    td_nxt          = td_r;
    cnt_nxt         = cnt_r;
    reduce_nxt      = reduce_r;
    r0_nxt          = r0_r;
    r1_nxt          = r1_r;
    t0_nxt          = t0_r;
    t1_nxt          = t1_r;
    pos_nxt         = pos_r;
    out_inverse_nxt = out_inverse_r;
    out_status_nxt  = out_status_r;

    // drop the result once the sink has taken it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mi_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (modulus_r == '0) begin
            // no modulus: report no inverse straight away
            r0_nxt    = '0;
            state_nxt = mi_pkg::ST_FINAL;
          end else begin
            // start the reduction of the value modulo m
            rem_nxt    = in_value;
            d_nxt      = modulus_r;
            acc_nxt    = '0;
            td_nxt     = '0;
            cnt_nxt    = '0;
            reduce_nxt = 1'b1;
            state_nxt  = mi_pkg::ST_ALIGN;
          end
        end
      end

      mi_pkg::ST_ALIGN: begin
        // scale divisor up while its double still fits under the remainder
        if (d_dbl <= {1'b0, rem_r}) begin
          d_nxt   = d_dbl[W-1:0];
          td_nxt  = {td_r[W-2:0], 1'b0};
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          state_nxt = mi_pkg::ST_SUB;
        end
      end

      mi_pkg::ST_SUB: begin
        // one quotient bit per cycle, highest first
        if (sub_ok) begin
          rem_nxt = rem_r - d_r;
          acc_nxt = acc_r + td_r;
        end
        if (cnt_r == '0) begin
          state_nxt = mi_pkg::ST_STEP;
        end else begin
          d_nxt   = {1'b0, d_r[W-1:1]};
          td_nxt  = {1'b0, td_r[W-1:1]};
          cnt_nxt = cnt_r - CW'(1);
        end
      end

      mi_pkg::ST_STEP: begin
        // advance the Euclid pair; the new remainder becomes r1
        reduce_nxt = 1'b0;
        r0_nxt     = step_r0;
        r1_nxt     = rem_r;
        t0_nxt     = step_t0;
        t1_nxt     = step_t1;
        pos_nxt    = step_pos;
        if (rem_r == '0) begin
          state_nxt = mi_pkg::ST_FINAL;
        end else begin
          rem_nxt   = step_r0;
          d_nxt     = rem_r;
          acc_nxt   = step_t0;
          td_nxt    = step_t1;
          cnt_nxt   = '0;
          state_nxt = mi_pkg::ST_ALIGN;
        end
      end

      mi_pkg::ST_FINAL: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (fail) begin
            out_inverse_nxt = '0;
            out_status_nxt  = mi_pkg::STATUS_NONE;
          end else begin
            out_inverse_nxt = (pos_r || mag == '0) ? mag : (modulus_r - mag);
            out_status_nxt  = mi_pkg::STATUS_OK;
          end
          state_nxt = mi_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mi_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r         <= rem_nxt;
    d_r           <= d_nxt;
    acc_r         <= acc_nxt;
    td_r          <= td_nxt;
    cnt_r         <= cnt_nxt;
    reduce_r      <= reduce_nxt;
    r0_r          <= r0_nxt;
    r1_r          <= r1_nxt;
    t0_r          <= t0_nxt;
    t1_r          <= t1_nxt;
    pos_r         <= pos_nxt;
    out_inverse_r <= out_inverse_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_stall    = (state_r != mi_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;
  assign out_status  = out_status_r;

  // A failed item always carries a zero inverse
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mi_pkg::STATUS_NONE |-> out_inverse == '0)
    else $error("non-invertible result with nonzero inverse");

  // An accepted transfer closes the input until the item completes
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input reopened right after a transfer");

  // The last quotient bit always hands over to the Euclid step
  a_sub_to_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mi_pkg::ST_SUB && cnt_r == '0 |=> state_r == mi_pkg::ST_STEP)
    else $error("divider did not finish into the step state");

  // The divisor is never zero while it is being scaled
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mi_pkg::ST_ALIGN |-> d_r != '0)
    else $error("zero divisor in the divider");

endmodule
